// ===== hdl/bac_pkg.sv =====
// Package: shared types, action codes and a helper function of the BCD alarm clock.
package bac_pkg;

    localparam int unsigned DAY_MINUTES = 1440;
    localparam logic [15:0] TPS_RESET   = 16'd1000;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_SET_TIME = 3'd1,
        ACT_SET_ALRM = 3'd2,
        ACT_TOGGLE   = 3'd3,
        ACT_SNOOZE   = 3'd4,
        ACT_CANCEL   = 3'd5
    } t_action;

    typedef struct packed {
        logic [2:0] action;
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [2:0] second_tens;
        logic [3:0] second_units;
        logic [7:0] snooze_minutes;
    } t_item;

    typedef struct packed {
        logic [15:0] prescale;
        logic [1:0]  ht;
        logic [3:0]  hu;
        logic [2:0]  mt;
        logic [3:0]  mu;
        logic [2:0]  st;
        logic [3:0]  su;
        logic        time_set;
        logic [1:0]  a_ht;
        logic [3:0]  a_hu;
        logic [2:0]  a_mt;
        logic [3:0]  a_mu;
        logic        alarm_en;
        logic [10:0] offset;
    } t_clk_state;

    typedef struct packed {
        logic [15:0] tick_phase;
        logic [1:0]  cur_hour_tens;
        logic [3:0]  cur_hour_units;
        logic [2:0]  cur_minute_tens;
        logic [3:0]  cur_minute_units;
        logic [2:0]  cur_second_tens;
        logic [3:0]  cur_second_units;
        logic        time_valid;
        logic        alarm_armed;
        logic        alarm_ring;
        logic        alarm_quiet;
    } t_result;

    // minute of the day from raw digits, not reduced (max 2785)
    function automatic logic [11:0] minute_of_day(input logic [1:0] ht, input logic [3:0] hu,
                                                  input logic [2:0] mt, input logic [3:0] mu);
        logic [11:0] hours;
        hours = 12'(ht) * 12'd10 + 12'(hu);
        return hours * 12'd60 + 12'(mt) * 12'd10 + 12'(mu);
    endfunction

endpackage

// ===== hdl/bac_req_if.sv =====
// Interface: request channel carrying one clock action and its digits.
interface bac_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
    logic [7:0] snooze_minutes;

    modport source (
        output valid, action, hour_tens, hour_units, minute_tens, minute_units,
               second_tens, second_units, snooze_minutes,
        input  ready
    );
    modport sink (
        input  valid, action, hour_tens, hour_units, minute_tens, minute_units,
               second_tens, second_units, snooze_minutes,
        output ready
    );
endinterface

// ===== hdl/bac_rsp_if.sv =====
// Interface: result channel carrying the clock status after each request.
interface bac_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] tick_phase;
    logic [1:0]  cur_hour_tens;
    logic [3:0]  cur_hour_units;
    logic [2:0]  cur_minute_tens;
    logic [3:0]  cur_minute_units;
    logic [2:0]  cur_second_tens;
    logic [3:0]  cur_second_units;
    logic        time_valid;
    logic        alarm_armed;
    logic        alarm_ring;
    logic        alarm_quiet;

    modport source (
        output valid, tick_phase, cur_hour_tens, cur_hour_units, cur_minute_tens,
               cur_minute_units, cur_second_tens, cur_second_units, time_valid,
               alarm_armed, alarm_ring, alarm_quiet,
        input  ready
    );
    modport sink (
        input  valid, tick_phase, cur_hour_tens, cur_hour_units, cur_minute_tens,
               cur_minute_units, cur_second_tens, cur_second_units, time_valid,
               alarm_armed, alarm_ring, alarm_quiet,
        output ready
    );
endinterface

// ===== hdl/bac_step.sv =====
// Next-state and result logic for one clock request.
module bac_step (
    input  bac_pkg::t_clk_state i_state,
    input  bac_pkg::t_item      i_item,
    input  logic [15:0]         i_tps,
    output bac_pkg::t_clk_state o_state,
    output bac_pkg::t_result    o_result
);
    import bac_pkg::*;

    localparam logic [12:0] DAY_13  = 13'(DAY_MINUTES);
    localparam logic [12:0] DAY2_13 = 13'(2 * DAY_MINUTES);
    localparam logic [10:0] DAY_11  = 11'(DAY_MINUTES);

    logic [15:0] limit;
    logic [1:0]  adv_ht;
    logic [3:0]  adv_hu;
    logic [2:0]  adv_mt;
    logic [3:0]  adv_mu;
    logic [2:0]  adv_st;
    logic [3:0]  adv_su;
    logic [11:0] now_min;
    logic [12:0] tgt_sum;
    logic [10:0] tgt_min;
    logic        match;
    logic [10:0] snz_sum;
    logic [10:0] snz_off;
    logic        ring;
    logic        quiet;
    t_clk_state  n_state;

    assign limit = (i_tps == 16'd0) ? 16'd0 : i_tps - 16'd1;

    // one-second advance with BCD carries; out-of-range digits carry early
    always_comb begin
        adv_ht = i_state.ht;
        adv_hu = i_state.hu;
        adv_mt = i_state.mt;
        adv_mu = i_state.mu;
        adv_st = i_state.st;
        adv_su = i_state.su;
        if (i_state.su < 4'd9) begin
            adv_su = i_state.su + 4'd1;
        end else begin
            adv_su = '0;
            if (i_state.st < 3'd5) begin
                adv_st = i_state.st + 3'd1;
            end else begin
                adv_st = '0;
                if (i_state.mu < 4'd9) begin
                    adv_mu = i_state.mu + 4'd1;
                end else begin
                    adv_mu = '0;
                    if (i_state.mt < 3'd5) begin
                        adv_mt = i_state.mt + 3'd1;
                    end else begin
                        adv_mt = '0;
                        if (i_state.ht >= 2'd2 && i_state.hu >= 4'd3) begin
                            adv_ht = '0;
                            adv_hu = '0;
                        end else if (i_state.hu >= 4'd9) begin
                            adv_hu = '0;
                            adv_ht = i_state.ht + 2'd1;
                        end else begin
                            adv_hu = i_state.hu + 4'd1;
                        end
                    end
                end
            end
        end
    end

    // alarm target: (alarm minute + offset) mod day, sum stays below three days
    assign now_min = minute_of_day(adv_ht, adv_hu, adv_mt, adv_mu);
    assign tgt_sum = 13'(minute_of_day(i_state.a_ht, i_state.a_hu, i_state.a_mt, i_state.a_mu))
                   + 13'(i_state.offset);
    always_comb begin
        if (tgt_sum >= DAY2_13) begin
            tgt_min = 11'(tgt_sum - DAY2_13);
        end else if (tgt_sum >= DAY_13) begin
            tgt_min = 11'(tgt_sum - DAY_13);
        end else begin
            tgt_min = 11'(tgt_sum);
        end
    end
    assign match = i_state.alarm_en && adv_st == 3'd0 && adv_su == 4'd0
                && now_min == 12'(tgt_min);

    assign snz_sum = i_state.offset + 11'(i_item.snooze_minutes);
    assign snz_off = (snz_sum >= DAY_11) ? snz_sum - DAY_11 : snz_sum;

    always_comb begin
        n_state = i_state;
        ring    = 1'b0;
        quiet   = 1'b0;
        case (t_action'(i_item.action))
            ACT_TICK: begin
                if (i_state.prescale >= limit) begin
                    n_state.prescale = '0;
                    if (i_state.time_set) begin
                        n_state.ht = adv_ht;
                        n_state.hu = adv_hu;
                        n_state.mt = adv_mt;
                        n_state.mu = adv_mu;
                        n_state.st = adv_st;
                        n_state.su = adv_su;
                        ring       = match;
                    end
                end else begin
                    n_state.prescale = i_state.prescale + 16'd1;
                end
            end
            ACT_SET_TIME: begin
                n_state.ht       = i_item.hour_tens;
                n_state.hu       = i_item.hour_units;
                n_state.mt       = i_item.minute_tens;
                n_state.mu       = i_item.minute_units;
                n_state.st       = i_item.second_tens;
                n_state.su       = i_item.second_units;
                n_state.time_set = 1'b1;
            end
            ACT_SET_ALRM: begin
                n_state.a_ht     = i_item.hour_tens;
                n_state.a_hu     = i_item.hour_units;
                n_state.a_mt     = i_item.minute_tens;
                n_state.a_mu     = i_item.minute_units;
                n_state.alarm_en = 1'b1;
            end
            ACT_TOGGLE: begin
                n_state.alarm_en = !i_state.alarm_en;
                n_state.offset   = '0;
            end
            ACT_SNOOZE: begin
                n_state.offset = snz_off;
                quiet          = 1'b1;
            end
            ACT_CANCEL: begin
                n_state.offset = '0;
                quiet          = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_state = n_state;

    always_comb begin
        o_result.tick_phase       = n_state.prescale;
        o_result.cur_hour_tens    = n_state.ht;
        o_result.cur_hour_units   = n_state.hu;
        o_result.cur_minute_tens  = n_state.mt;
        o_result.cur_minute_units = n_state.mu;
        o_result.cur_second_tens  = n_state.st;
        o_result.cur_second_units = n_state.su;
        o_result.time_valid       = n_state.time_set;
        o_result.alarm_armed      = n_state.alarm_en;
        o_result.alarm_ring       = ring;
        o_result.alarm_quiet      = quiet;
    end

endmodule

// ===== hdl/bcd_alarm_clock_unit.sv =====
// A request taken into the input reg passes into the result reg once the result reg can load.
// Throughput: one request per cycle unless stalled; the update is one pass from input reg to result reg.
// While a stalled result waits, the input reg still takes one request, then ready drops.
// Reset: synchronous, active low; clears time, alarm, snooze offset, prescaler and both
// valid flags, and loads ticks_per_second with 1000.
module bcd_alarm_clock_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    bac_req_if.sink     i_req,
    bac_rsp_if.source   o_rsp
);
    import bac_pkg::*;

    logic        r_in_valid;
    t_item       r_item;
    logic        r_out_valid;
    t_result     r_result;
    t_clk_state  r_state;
    logic [15:0] r_tps;

    t_clk_state  n_state;
    t_result     n_result;
    logic        w_out_load;
    logic        w_step;
    logic        w_in_take;

    assign w_out_load  = !r_out_valid || o_rsp.ready;
    assign w_step      = r_in_valid && w_out_load;
    assign i_req.ready = !r_in_valid || w_out_load;
    assign w_in_take   = i_req.valid && i_req.ready;

    bac_step u_step (
        .i_state  (r_state),
        .i_item   (r_item),
        .i_tps    (r_tps),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_tps       <= TPS_RESET;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
            if (w_step) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.action         <= i_req.action;
            r_item.hour_tens      <= i_req.hour_tens;
            r_item.hour_units     <= i_req.hour_units;
            r_item.minute_tens    <= i_req.minute_tens;
            r_item.minute_units   <= i_req.minute_units;
            r_item.second_tens    <= i_req.second_tens;
            r_item.second_units   <= i_req.second_units;
            r_item.snooze_minutes <= i_req.snooze_minutes;
        end
        if (w_step) begin
            r_result <= n_result;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.tick_phase       = r_result.tick_phase;
    assign o_rsp.cur_hour_tens    = r_result.cur_hour_tens;
    assign o_rsp.cur_hour_units   = r_result.cur_hour_units;
    assign o_rsp.cur_minute_tens  = r_result.cur_minute_tens;
    assign o_rsp.cur_minute_units = r_result.cur_minute_units;
    assign o_rsp.cur_second_tens  = r_result.cur_second_tens;
    assign o_rsp.cur_second_units = r_result.cur_second_units;
    assign o_rsp.time_valid       = r_result.time_valid;
    assign o_rsp.alarm_armed      = r_result.alarm_armed;
    assign o_rsp.alarm_ring       = r_result.alarm_ring;
    assign o_rsp.alarm_quiet      = r_result.alarm_quiet;

    // a ring only comes with a valid, armed clock sitting on a whole minute
    a_ring_context: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.alarm_ring) |->
            (o_rsp.time_valid && o_rsp.alarm_armed &&
             o_rsp.cur_second_tens == 3'd0 && o_rsp.cur_second_units == 4'd0))
        else $error("alarm ring outside a whole armed minute");

    a_ring_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.alarm_ring && o_rsp.alarm_quiet))
        else $error("ring and quiet raised together");

    // clock state only moves when a request passes into the result reg
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |=> $stable(r_state))
        else $error("clock state changed without a request");

    // a stalled result must not be overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_result)))
        else $error("stalled result overwritten");

endmodule

// ===== verif/bcd_alarm_clock_unit_test.sv =====
// Self-checking testbench for the BCD alarm clock unit, with a clock-state predictor.
`timescale 1ns / 1ps

module bcd_alarm_clock_unit_test;
    import bac_pkg::*;

    localparam logic [2:0] ACT_RSVD_A  = 3'd6;
    localparam logic [2:0] ACT_RSVD_B  = 3'd7;
    localparam int         STALL_LIMIT = 4000;
    localparam int         PHASE_REQS  = 140;
    localparam int         MAX_PRINTS  = 40;

    class clock_status_predictor;
        logic [15:0] rate;
        logic [15:0] phase;
        logic [1:0]  ht;
        logic [3:0]  hu;
        logic [2:0]  mt;
        logic [3:0]  mu;
        logic [2:0]  st;
        logic [3:0]  su;
        logic        time_ok;
        logic [1:0]  a_ht;
        logic [3:0]  a_hu;
        logic [2:0]  a_mt;
        logic [3:0]  a_mu;
        logic        armed;
        int unsigned offset;
        t_result     pending_status[$];
        int          errors;
        int          requests;
        int          checked;
        int          rings;

        function new();
            rate = TPS_RESET;
            phase = '0;
            {ht, hu, mt, mu, st, su} = '0;
            {a_ht, a_hu, a_mt, a_mu} = '0;
            time_ok = 1'b0;
            armed = 1'b0;
            offset = 0;
            errors = 0;
            requests = 0;
            checked = 0;
            rings = 0;
        endfunction

        function void set_rate(logic [15:0] v);
            rate = v;
        endfunction

        function int pending();
            return pending_status.size();
        endfunction

        // minutes since midnight from raw digits, no reduction
        static function int day_minute(int h1, int h0, int m1, int m0);
            return (h1 * 10 + h0) * 60 + m1 * 10 + m0;
        endfunction

        function void note_request(t_item it);
            int      limit;
            logic    ring;
            logic    quiet;
            t_result r;
            ring = 1'b0;
            quiet = 1'b0;
            case (it.action)
                ACT_TICK: begin
                    // a rate of zero behaves as one tick per second
                    limit = (rate == 0) ? 0 : int'(rate) - 1;
                    if (int'(phase) >= limit) begin
                        if (time_ok) begin
                            if (su < 9) su++;
                            else begin
                                su = '0;
                                if (st < 5) st++;
                                else begin
                                    st = '0;
                                    if (mu < 9) mu++;
                                    else begin
                                        mu = '0;
                                        if (mt < 5) mt++;
                                        else begin
                                            mt = '0;
                                            if (ht >= 2 && hu >= 3) begin
                                                ht = '0;
                                                hu = '0;
                                            end else if (hu >= 9) begin
                                                hu = '0;
                                                ht = ht + 2'd1;
                                            end else begin
                                                hu++;
                                            end
                                        end
                                    end
                                end
                            end
                            ring = armed && st == 0 && su == 0 &&
                                   day_minute(ht, hu, mt, mu) ==
                                   (day_minute(a_ht, a_hu, a_mt, a_mu) + offset) % DAY_MINUTES;
                        end
                        phase = '0;
                    end else begin
                        phase = phase + 16'd1;
                    end
                end
                ACT_SET_TIME: begin
                    {ht, hu, mt, mu} = {it.hour_tens, it.hour_units, it.minute_tens,
                                        it.minute_units};
                    {st, su} = {it.second_tens, it.second_units};
                    time_ok = 1'b1;
                end
                ACT_SET_ALRM: begin
                    {a_ht, a_hu, a_mt, a_mu} = {it.hour_tens, it.hour_units, it.minute_tens,
                                                it.minute_units};
                    armed = 1'b1;
                end
                ACT_TOGGLE: begin
                    armed = !armed;
                    offset = 0;
                end
                ACT_SNOOZE: begin
                    offset = (offset + it.snooze_minutes) % DAY_MINUTES;
                    quiet = 1'b1;
                end
                ACT_CANCEL: begin
                    offset = 0;
                    quiet = 1'b1;
                end
                default: ;
            endcase
            r.tick_phase = phase;
            r.cur_hour_tens = ht;
            r.cur_hour_units = hu;
            r.cur_minute_tens = mt;
            r.cur_minute_units = mu;
            r.cur_second_tens = st;
            r.cur_second_units = su;
            r.time_valid = time_ok;
            r.alarm_armed = armed;
            r.alarm_ring = ring;
            r.alarm_quiet = quiet;
            pending_status.push_back(r);
            requests++;
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("result %0d %s: got %0d, expected %0d",
                                 checked, name, got, want));
        endtask

        task check_status(t_result got);
            t_result want;
            if (pending_status.size() == 0) begin
                report("result with no request waiting");
            end else begin
                want = pending_status.pop_front();
                compare_field("tick_phase", got.tick_phase, want.tick_phase);
                compare_field("cur_hour_tens", got.cur_hour_tens, want.cur_hour_tens);
                compare_field("cur_hour_units", got.cur_hour_units, want.cur_hour_units);
                compare_field("cur_minute_tens", got.cur_minute_tens, want.cur_minute_tens);
                compare_field("cur_minute_units", got.cur_minute_units, want.cur_minute_units);
                compare_field("cur_second_tens", got.cur_second_tens, want.cur_second_tens);
                compare_field("cur_second_units", got.cur_second_units, want.cur_second_units);
                compare_field("time_valid", got.time_valid, want.time_valid);
                compare_field("alarm_armed", got.alarm_armed, want.alarm_armed);
                compare_field("alarm_ring", got.alarm_ring, want.alarm_ring);
                compare_field("alarm_quiet", got.alarm_quiet, want.alarm_quiet);
                if (want.alarm_ring) rings++;
                checked++;
            end
        endtask

        task final_check();
            while (pending_status.size() != 0) begin
                report("request never produced a result");
                void'(pending_status.pop_front());
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    bit          steady_flow;
    int          idle_cycles;

    clock_status_predictor sb = new();

    bac_req_if req_bus();
    bac_rsp_if rsp_bus();

    bcd_alarm_clock_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_bus.sink),
        .o_rsp       (rsp_bus.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly back to back, some short gaps, a few long ones
    function int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function t_item fixed_item(logic [2:0] act, logic [1:0] h1, logic [3:0] h0,
                               logic [2:0] m1, logic [3:0] m0, logic [2:0] s1,
                               logic [3:0] s0, logic [7:0] sn);
        t_item it;
        it.action = act;
        it.hour_tens = h1;
        it.hour_units = h0;
        it.minute_tens = m1;
        it.minute_units = m0;
        it.second_tens = s1;
        it.second_units = s0;
        it.snooze_minutes = sn;
        return it;
    endfunction

    // unused fields stay random so every input bit moves
    function t_item random_item(logic [2:0] act);
        t_item it;
        it = t_item'($bits(t_item)'($urandom));
        it.action = act;
        return it;
    endfunction

    function t_item time_item(logic [2:0] act, int m, int sec);
        t_item it;
        it = random_item(act);
        it.hour_tens = 2'((m / 60) / 10);
        it.hour_units = 4'((m / 60) % 10);
        it.minute_tens = 3'((m % 60) / 10);
        it.minute_units = 4'((m % 60) % 10);
        it.second_tens = 3'(sec / 10);
        it.second_units = 4'(sec % 10);
        return it;
    endfunction

    function t_item noise_item();
        if ($urandom_range(0, 9) < 5) return random_item(ACT_TICK);
        return random_item(3'($urandom_range(1, 7)));
    endfunction

    task send_request(t_item it);
        int gap;
        gap = steady_flow ? 0 : idle_gap();
        repeat (gap) begin
            @(negedge i_clk);
            req_bus.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_bus.valid <= 1'b1;
        req_bus.action <= it.action;
        req_bus.hour_tens <= it.hour_tens;
        req_bus.hour_units <= it.hour_units;
        req_bus.minute_tens <= it.minute_tens;
        req_bus.minute_units <= it.minute_units;
        req_bus.second_tens <= it.second_tens;
        req_bus.second_units <= it.second_units;
        req_bus.snooze_minutes <= it.snooze_minutes;
        do @(posedge i_clk); while (!req_bus.ready);
        sb.note_request(it);
    endtask

    task wait_drained();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task write_rate(logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_rate(v);
    endtask

    // alarm set a minute ahead of the clock, then ticks to cross the minute, fewer when more than 60 would be needed
    task run_alarm_sequence(logic [15:0] rate);
        int alarm_min;
        int snz;
        int start;
        int sec;
        int eff;
        int n_ticks;
        alarm_min = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 9)
                                                : $urandom_range(0, DAY_MINUTES - 1);
        snz = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 30) : 0;
        send_request(random_item(ACT_CANCEL));
        send_request(time_item(ACT_SET_ALRM, alarm_min, 0));
        if ($urandom_range(0, 5) == 0) send_request(random_item(ACT_TOGGLE));
        if (snz != 0) begin
            t_item it;
            it = random_item(ACT_SNOOZE);
            it.snooze_minutes = 8'(snz);
            send_request(it);
        end
        eff = (rate == 0) ? 1 : int'(rate);
        start = (alarm_min + snz + DAY_MINUTES - 1) % DAY_MINUTES;
        sec = 60 - $urandom_range(1, (50 / eff > 1) ? 50 / eff : 1);
        send_request(time_item(ACT_SET_TIME, start, sec));
        n_ticks = (60 - sec) * eff + $urandom_range(0, 3);
        if (n_ticks > 60) n_ticks = $urandom_range(20, 60);
        repeat (n_ticks) begin
            if ($urandom_range(0, 19) == 0) send_request(noise_item());
            else send_request(random_item(ACT_TICK));
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got.tick_phase = rsp_bus.tick_phase;
            got.cur_hour_tens = rsp_bus.cur_hour_tens;
            got.cur_hour_units = rsp_bus.cur_hour_units;
            got.cur_minute_tens = rsp_bus.cur_minute_tens;
            got.cur_minute_units = rsp_bus.cur_minute_units;
            got.cur_second_tens = rsp_bus.cur_second_tens;
            got.cur_second_units = rsp_bus.cur_second_units;
            got.time_valid = rsp_bus.time_valid;
            got.alarm_armed = rsp_bus.alarm_armed;
            got.alarm_ring = rsp_bus.alarm_ring;
            got.alarm_quiet = rsp_bus.alarm_quiet;
            sb.check_status(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        idle_cycles = 0;
        wait (idle_cycles >= STALL_LIMIT);
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // result side back pressure
    initial begin
        int stall;
        stall = 0;
        rsp_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                stall--;
            end else begin
                rsp_bus.ready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 3) == 0) stall = idle_gap();
            end
        end
    end

    initial begin
        logic [15:0] rate_plan [8];
        int          base;
        rate_plan = '{16'd1, 16'd2, 16'hFFFF, 16'd1, 16'd3, 16'd0, 16'd6, 16'd1};
        rate_plan[6] = 16'($urandom_range(1, 6));
        steady_flow = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_bus.valid = 1'b0;
        req_bus.action = ACT_TICK;
        req_bus.hour_tens = '0;
        req_bus.hour_units = '0;
        req_bus.minute_tens = '0;
        req_bus.minute_units = '0;
        req_bus.second_tens = '0;
        req_bus.second_units = '0;
        req_bus.snooze_minutes = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ticks before the time is set only move the prescaler
        repeat (3) send_request(fixed_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_request(fixed_item(ACT_RSVD_A, 3, 15, 7, 15, 7, 15, 255));
        send_request(fixed_item(ACT_RSVD_B, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();
        // rate zero with the prescaler already past the new limit
        write_rate(16'd0);
        send_request(fixed_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_request(fixed_item(ACT_SET_ALRM, 0, 0, 0, 0, 0, 0, 0));
        send_request(fixed_item(ACT_SET_TIME, 2, 3, 5, 9, 5, 9, 0));
        send_request(fixed_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
        // six snoozes of 255 wrap the offset past a full day
        repeat (6) send_request(fixed_item(ACT_SNOOZE, 0, 0, 0, 0, 0, 0, 255));
        send_request(fixed_item(ACT_CANCEL, 0, 0, 0, 0, 0, 0, 0));
        send_request(fixed_item(ACT_TOGGLE, 0, 0, 0, 0, 0, 0, 0));
        send_request(fixed_item(ACT_TOGGLE, 0, 0, 0, 0, 0, 0, 0));
        // out of range digits carry and wrap straight to midnight
        send_request(fixed_item(ACT_SET_TIME, 3, 15, 7, 15, 7, 15, 255));
        send_request(fixed_item(ACT_TICK, 3, 15, 7, 15, 7, 15, 255));
        send_request(fixed_item(ACT_SET_ALRM, 3, 15, 7, 15, 7, 15, 255));
        send_request(fixed_item(ACT_SET_TIME, 2, 2, 2, 4, 5, 9, 0));
        send_request(fixed_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_request(fixed_item(ACT_SET_TIME, 0, 0, 0, 0, 0, 0, 0));
        send_request(fixed_item(ACT_TICK, 0, 0, 0, 0, 0, 0, 0));

        foreach (rate_plan[p]) begin
            wait_drained();
            write_rate(rate_plan[p]);
            steady_flow = (p % 3 == 1);
            base = sb.requests;
            while (sb.requests - base < PHASE_REQS) begin
                if ($urandom_range(0, 3) == 0) send_request(noise_item());
                else run_alarm_sequence(rate_plan[p]);
                if ($urandom_range(0, 39) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        sb.final_check();
        $display("Sent %0d requests over %0d prescaler settings, zero and 65535 among them.",
                 sb.requests, $size(rate_plan) + 2);
        $display("Checked %0d results, %0d alarm rings, %0d mismatches.",
                 sb.checked, sb.rings, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
